// File: design/refcounted_probing_hash_cache_top_assert.svh
// Assertion macros for the hash cache top level.
`ifndef REFCOUNTED_PROBING_HASH_CACHE_TOP_ASSERT_SVH
`define REFCOUNTED_PROBING_HASH_CACHE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RPHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rphc: same-cycle check failed");
`define RPHC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rphc: next-cycle check failed");
`else
`define RPHC_ASSERT_IMP(lbl, ante, cons)
`define RPHC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: design/rphc_pkg.sv
package rphc_pkg;

  localparam int MAX_HASH_BITS = 8;
  localparam int TABLE_SIZE    = 1 << MAX_HASH_BITS;
  localparam int IDX_W         = MAX_HASH_BITS;
  localparam int BITS_W        = $clog2(MAX_HASH_BITS + 1);
  localparam int PROBE_MAX     = MAX_HASH_BITS * 3 / 2;
  localparam int PROBE_W       = $clog2(PROBE_MAX + 1);
  localparam int HB_W          = 4;
  localparam int KEY_W         = 64;
  localparam int PAY_W         = 64;
  localparam int REF_W         = 16;
  localparam int TAG_W         = KEY_W + REF_W;
  localparam int SLOT_W        = 8;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_INSERT  = 2'd0;
  localparam mode_t MODE_LOOKUP  = 2'd1;
  localparam mode_t MODE_RELEASE = 2'd2;
  localparam mode_t MODE_NONE    = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_MISS  = 2'd1;
  localparam status_t ST_ZERO  = 2'd2;
  localparam status_t ST_UNDER = 2'd3;

  localparam logic [HB_W-1:0] HB_RESET = 4'd8;

  // one bucket's tag word: key plus reference count
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [REF_W-1:0] refs;
  } tag_t;

endpackage

// File: design/rphc_ram.sv
module rphc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/refcounted_probing_hash_cache_top.sv
// Reference-counted linear-probing hash cache, one memory read per probe.
// Insert/lookup: p = buckets probed (1 .. hash_bits*3/2, at most 12); the
// result is strobed in the first cycle with busy low. Release checks only the slot's bucket.
// A zero key on insert/lookup and mode 3 are answered (or dropped) at accept, busy never rises.
// Rate is set by the single tag memory read port: one bucket per cycle.
// Sync active-low reset clears per-bucket valid flags (no sweep), hash_bits=8.
`include "refcounted_probing_hash_cache_top_assert.svh"

module refcounted_probing_hash_cache_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // item channel
  input  logic                       start,
  output logic                       busy,
  input  rphc_pkg::mode_t            in_mode,
  input  logic [rphc_pkg::KEY_W-1:0] in_key,
  input  logic [rphc_pkg::PAY_W-1:0] in_payload_in,
  input  logic [rphc_pkg::SLOT_W-1:0] in_slot_in,
  // results
  output logic                       out_valid,
  output rphc_pkg::status_t          out_status,
  output logic [rphc_pkg::SLOT_W-1:0] out_slot_out,
  output logic [rphc_pkg::PAY_W-1:0] out_payload_out,
  // hash_bits register write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rphc_pkg::HB_W-1:0]  cfg_data
);
  import rphc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;   // first read in flight
  localparam logic [1:0] S_PROBE = 2'd2;   // check one bucket per cycle

  logic [1:0]         state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [IDX_W-1:0]   mask_r, mask_nxt;
  logic [PROBE_W-1:0] left_r, left_nxt;
  logic [HB_W-1:0]    hb_r;

  logic               out_valid_r, out_valid_nxt;
  status_t            status_r, status_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [PAY_W-1:0]   pout_r, pout_nxt;

  // per-bucket written flags; an unwritten bucket reads as key 0, count 0
  logic [TABLE_SIZE-1:0] valid_r;
  logic                  valid_rd_r;

  logic [IDX_W-1:0]   raddr;
  logic [IDX_W-1:0]   addr_inc;
  tag_t               tag_rdata, rd_tag, tag_wdata;
  logic               tag_we, pay_we;
  logic [PAY_W-1:0]   pay_rdata;

  logic [BITS_W-1:0]  eff_bits;
  logic [IDX_W-1:0]   eff_mask;
  logic [PROBE_W-1:0] eff_probes;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);

  // clamp hash_bits to 1..MAX_HASH_BITS
  always_comb begin
    if (hb_r == '0) begin
      eff_bits = BITS_W'(1);
    end else if (32'(hb_r) > MAX_HASH_BITS) begin
      eff_bits = BITS_W'(MAX_HASH_BITS);
    end else begin
      eff_bits = BITS_W'(hb_r);
    end
    eff_mask   = ~({IDX_W{1'b1}} << eff_bits);
    eff_probes = PROBE_W'(eff_bits) + PROBE_W'(eff_bits >> 1);
  end

  assign addr_inc = (addr_r + IDX_W'(1)) & mask_r;
  // in PROBE the next bucket is read while the current one is checked
  assign raddr    = (state_r == S_PROBE) ? addr_inc : addr_r;
  assign rd_tag   = valid_rd_r ? tag_rdata : '0;

  rphc_ram #(.WIDTH(TAG_W), .DEPTH(TABLE_SIZE)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (addr_r),
    .wdata (tag_wdata),
    .raddr (raddr),
    .rdata (tag_rdata)
  );

  rphc_ram #(.WIDTH(PAY_W), .DEPTH(TABLE_SIZE)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (addr_r),
    .wdata (pay_r),
    .raddr (raddr),
    .rdata (pay_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    addr_nxt      = addr_r;
    mask_nxt      = mask_r;
    left_nxt      = left_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    pout_nxt      = pout_r;
    tag_we        = 1'b0;
    pay_we        = 1'b0;
    tag_wdata     = rd_tag;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          key_nxt  = in_key;
          pay_nxt  = in_payload_in;
          if (in_mode == MODE_RELEASE) begin
            addr_nxt  = IDX_W'(in_slot_in);
            state_nxt = S_READ;
          end else if (in_mode == MODE_NONE) begin
            state_nxt = S_IDLE;
          end else if (in_key == '0) begin
            out_valid_nxt = 1'b1;
            status_nxt    = ST_ZERO;
            slot_nxt      = '0;
            pout_nxt      = '0;
          end else begin
            addr_nxt  = in_key[IDX_W-1:0] & eff_mask;
            mask_nxt  = eff_mask;
            left_nxt  = eff_probes - PROBE_W'(1);
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        state_nxt = S_PROBE;
      end

      S_PROBE: begin
        pout_nxt = '0;
        slot_nxt = SLOT_W'(addr_r);
        if (mode_r == MODE_RELEASE) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (rd_tag.refs == '0) begin
            status_nxt = ST_UNDER;
          end else begin
            status_nxt     = ST_OK;
            tag_we         = 1'b1;
            tag_wdata.refs = rd_tag.refs - REF_W'(1);
          end
        end else if ((mode_r == MODE_INSERT) && (rd_tag.refs == '0)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          status_nxt    = ST_OK;
          tag_we        = 1'b1;
          pay_we        = 1'b1;
          tag_wdata.key  = key_r;
          tag_wdata.refs = REF_W'(1);
        end else if ((mode_r == MODE_LOOKUP) && (rd_tag.key == key_r)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          status_nxt    = ST_OK;
          pout_nxt      = pay_rdata;
          tag_we        = 1'b1;
          if (rd_tag.refs != '1) begin
            tag_wdata.refs = rd_tag.refs + REF_W'(1);
          end
        end else if (left_r == '0) begin
          // probe window exhausted
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          status_nxt    = ST_MISS;
          slot_nxt      = '0;
        end else begin
          left_nxt = left_r - PROBE_W'(1);
          addr_nxt = addr_inc;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hb_r        <= HB_RESET;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        hb_r <= cfg_data;
      end
      if (tag_we) begin
        valid_r[addr_r] <= 1'b1;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    left_r     <= left_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    pout_r     <= pout_nxt;
    valid_rd_r <= valid_r[raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_slot_out    = slot_r;
  assign out_payload_out = pout_r;

  // results only appear once the sequencer is back in idle
  `RPHC_ASSERT_IMP(a_out_in_idle, out_valid_r, state_r == S_IDLE)
  // memory writes only happen while checking a bucket
  `RPHC_ASSERT_IMP(a_we_in_probe, tag_we || pay_we, state_r == S_PROBE)
  // every bucket update is followed by its result
  `RPHC_ASSERT_NXT(a_we_then_out, tag_we, out_valid_r && (status_r == ST_OK))
  // a read always leads straight into probing
  `RPHC_ASSERT_NXT(a_read_to_probe, state_r == S_READ, state_r == S_PROBE)

endmodule
